// ----- design/mcpd_pkg.sv -----
// ----------------------------------------------------------------------------
// mcpd_pkg: shared constants for the motion compensated pair distance block
// Field widths, distance saturation value, gate reset value and the residual
// width rule used by both the residual datapath and the top level.
// ----------------------------------------------------------------------------
package mcpd_pkg;

  localparam int POS_W      = 24;  // position, 2^-10 m, signed
  localparam int VEL_W      = 18;  // velocity, 2^-10 m/s, signed
  localparam int TIME_W     = 48;  // timestamp, 2^-16 s ticks, unsigned
  localparam int DIST_W     = 26;  // distances and cost, 2^-10 m, unsigned
  localparam int FRAC_SHIFT = 16;  // drop time fraction from v * dt

  localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
  localparam logic [DIST_W-1:0] GATE_RESET = DIST_W'(4096);

  // Signed width of one residual component for a given dt limit:
  // position difference (POS_W+1) or displacement (limit + 4), plus a sign bit.
  function automatic int resid_w(input int limit_bits);
    int disp_w;
    int diff_w;
    disp_w = limit_bits + 4;
    diff_w = POS_W + 1;
    return ((diff_w > disp_w) ? diff_w : disp_w) + 1;
  endfunction

endpackage

// ----- design/mcpd_resid.sv -----
// ----------------------------------------------------------------------------
// mcpd_resid: squared residual of one constant velocity prediction
// Four stages: products v*dt, component residuals with magnitude, squares,
// and the sum of squares. Advances every cycle; valid travels with the data.
// ----------------------------------------------------------------------------
module mcpd_resid
  import mcpd_pkg::*;
#(
  parameter int DT_LIMIT_BITS = 20
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  logic signed [POS_W-1:0]                   ax_i,
  input  logic signed [POS_W-1:0]                   ay_i,
  input  logic signed [VEL_W-1:0]                   vx_i,
  input  logic signed [VEL_W-1:0]                   vy_i,
  input  logic signed [POS_W-1:0]                   bx_i,
  input  logic signed [POS_W-1:0]                   by_i,
  input  logic signed [DT_LIMIT_BITS+1:0]           dt_i,
  output logic                                      valid_o,
  output logic [2*resid_w(DT_LIMIT_BITS):0]         sum_o
);

  localparam int DT_W   = DT_LIMIT_BITS + 2;
  localparam int PROD_W = VEL_W + DT_W;
  localparam int RW     = resid_w(DT_LIMIT_BITS);
  localparam int SQ_W   = 2 * RW;
  localparam int SUM_W  = SQ_W + 1;

  logic                      v1_q, v2_q, v3_q, v4_q;
  logic signed [PROD_W-1:0]  px_q, py_q;
  logic signed [POS_W:0]     ddx_q, ddy_q;
  logic signed [PROD_W-1:0]  dispx, dispy;
  logic signed [RW-1:0]      rx, ry;
  logic [RW-1:0]             magx_d, magy_d, magx_q, magy_q;
  logic [SQ_W-1:0]           sqx_q, sqy_q;
  logic [SUM_W-1:0]          sum_q;

  // Floor of v*dt / 2^16, then residual = (b - a) - displacement.
  always_comb begin
    dispx  = px_q >>> FRAC_SHIFT;
    dispy  = py_q >>> FRAC_SHIFT;
    rx     = RW'(ddx_q) - RW'(dispx);
    ry     = RW'(ddy_q) - RW'(dispy);
    magx_d = rx[RW-1] ? RW'(-rx) : RW'(rx);
    magy_d = ry[RW-1] ? RW'(-ry) : RW'(ry);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    px_q   <= vx_i * dt_i;
    py_q   <= vy_i * dt_i;
    ddx_q  <= (POS_W+1)'(bx_i) - (POS_W+1)'(ax_i);
    ddy_q  <= (POS_W+1)'(by_i) - (POS_W+1)'(ay_i);
    magx_q <= magx_d;
    magy_q <= magy_d;
    sqx_q  <= magx_q * magx_q;
    sqy_q  <= magy_q * magy_q;
    sum_q  <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
  end

  assign valid_o = v4_q;
  assign sum_o   = sum_q;

endmodule

// ----- design/mcpd_isqrt.sv -----
// ----------------------------------------------------------------------------
// mcpd_isqrt: pipelined integer square root, rounded down, saturated
// One result bit per stage (restoring digit recurrence), then a clamp stage
// that limits the root to the distance range.
// ----------------------------------------------------------------------------
module mcpd_isqrt
  import mcpd_pkg::*;
#(
  parameter int IN_W = 53
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  logic [IN_W-1:0]   rad_i,
  output logic              valid_o,
  output logic [DIST_W-1:0] dist_o
);

  localparam int RB  = (IN_W + 1) / 2;  // root bits
  localparam int NW  = 2 * RB;          // padded radicand
  localparam int RMW = RB + 3;          // remainder width

  logic [NW-1:0]  rad_p  [RB];
  logic [RMW-1:0] rem_p  [RB];
  logic [RB-1:0]  root_p [RB];
  logic           v_p    [RB];

  logic [NW-1:0]  rad_d  [RB];
  logic [RMW-1:0] rem_d  [RB];
  logic [RB-1:0]  root_d [RB];

  logic [NW-1:0]  rad_q  [RB];
  logic [RMW-1:0] rem_q  [RB];
  logic [RB-1:0]  root_q [RB];
  logic           v_q    [RB];

  logic [RMW-1:0] r_sh   [RB];
  logic [RMW-1:0] trial  [RB];

  logic              vout_q;
  logic [DIST_W-1:0] dist_q;

  // Stage inputs: first stage from the port, the rest from the stage before.
  always_comb begin
    rad_p[0]  = NW'(rad_i);
    rem_p[0]  = '0;
    root_p[0] = '0;
    v_p[0]    = valid_i;
    for (int k = 1; k < RB; k++) begin
      rad_p[k]  = rad_q[k-1];
      rem_p[k]  = rem_q[k-1];
      root_p[k] = root_q[k-1];
      v_p[k]    = v_q[k-1];
    end
  end

  // Bring down two radicand bits, try root*4+1, keep the remainder if it fits.
  always_comb begin
    for (int k = 0; k < RB; k++) begin
      r_sh[k]  = {rem_p[k][RMW-3:0], rad_p[k][NW-1 -: 2]};
      trial[k] = RMW'({root_p[k], 2'b01});
      rad_d[k] = rad_p[k] << 2;
      if (r_sh[k] >= trial[k]) begin
        rem_d[k]  = r_sh[k] - trial[k];
        root_d[k] = {root_p[k][RB-2:0], 1'b1};
      end else begin
        rem_d[k]  = r_sh[k];
        root_d[k] = {root_p[k][RB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < RB; k++) begin
        v_q[k] <= 1'b0;
      end
      vout_q <= 1'b0;
    end else begin
      for (int k = 0; k < RB; k++) begin
        v_q[k] <= v_p[k];
      end
      vout_q <= v_q[RB-1];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < RB; k++) begin
      rad_q[k]  <= rad_d[k];
      rem_q[k]  <= rem_d[k];
      root_q[k] <= root_d[k];
    end
    dist_q <= (root_q[RB-1] > RB'(DIST_MAX)) ? DIST_MAX : root_q[RB-1][DIST_W-1:0];
  end

  assign valid_o = vout_q;
  assign dist_o  = dist_q;

endmodule

// ----- design/motion_compensated_pair_distance.sv -----
// ----------------------------------------------------------------------------
// motion_compensated_pair_distance: constant velocity gating distance
// Predicts track and object to each other's time, takes both planar
// residuals, averages them into a pair cost and gates it against a threshold.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive a track/object pair on the field ports and raise start; the
//   beat is taken at any rising edge with start high and busy low. busy stays
//   low, so a new pair may enter on every cycle.
//   Output: done is high for exactly one cycle per pair, with forward_dist,
//   backward_dist, pair_cost and within_gate valid in that cycle. Results
//   leave in input order. The receiver cannot stall; nothing is held back.
//   Pipeline: clamp stage, residual pipelines, square root pipelines, cost
//   stage and output register. The square root pipeline, one root bit per
//   stage, is the longest part; throughput is one pair per cycle.
//   Config: one register, the gate threshold, written through cfg_valid_i /
//   cfg_data_i; cfg_ready_o is always high. Write it only while no pair is in
//   flight; the gate compare reads it in the last stage.
//   Reset: rst_ni (async, active low) drops all in-flight beats and loads the
//   threshold with 4096 (4 m).
// ----------------------------------------------------------------------------
module motion_compensated_pair_distance
  import mcpd_pkg::*;
#(
  parameter int DT_LIMIT_BITS = 20
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // command channel
  input  logic                     start,
  output logic                     busy,
  input  logic signed [POS_W-1:0]  track_x_i,
  input  logic signed [POS_W-1:0]  track_y_i,
  input  logic signed [VEL_W-1:0]  track_vx_i,
  input  logic signed [VEL_W-1:0]  track_vy_i,
  input  logic [TIME_W-1:0]        track_time_i,
  input  logic signed [POS_W-1:0]  obj_x_i,
  input  logic signed [POS_W-1:0]  obj_y_i,
  input  logic signed [VEL_W-1:0]  obj_vx_i,
  input  logic signed [VEL_W-1:0]  obj_vy_i,
  input  logic [TIME_W-1:0]        obj_time_i,
  // result channel
  output logic                     done,
  output logic [DIST_W-1:0]        forward_dist_o,
  output logic [DIST_W-1:0]        backward_dist_o,
  output logic [DIST_W-1:0]        pair_cost_o,
  output logic                     within_gate_o,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [DIST_W-1:0]        cfg_data_i
);

  localparam int TD_W  = TIME_W + 1;
  localparam int DT_W  = DT_LIMIT_BITS + 2;
  localparam int RW    = resid_w(DT_LIMIT_BITS);
  localparam int SUM_W = 2 * RW + 1;

  localparam logic signed [TD_W-1:0] DT_HI = {{(TD_W-1){1'b0}}, 1'b1} << DT_LIMIT_BITS;
  localparam logic signed [TD_W-1:0] DT_LO = -DT_HI;

  logic                    take;
  logic [DIST_W-1:0]       max_dist_q;

  // stage 0: time differences, clamped, and the captured fields
  logic signed [TD_W-1:0]  dtf_full, dtb_full;
  logic signed [TD_W-1:0]  dtf_c, dtb_c;
  logic                    v0_q;
  logic signed [DT_W-1:0]  dtf_q, dtb_q;
  logic signed [POS_W-1:0] tx_q, ty_q, ox_q, oy_q;
  logic signed [VEL_W-1:0] tvx_q, tvy_q, ovx_q, ovy_q;

  // residual and root pipelines
  logic                    fres_v, bres_v;
  logic [SUM_W-1:0]        fres_sum, bres_sum;
  logic                    fdist_v, bdist_v;
  logic [DIST_W-1:0]       fdist, bdist;

  // cost stage and output register
  logic                    vc_q;
  logic [DIST_W-1:0]       fwd_q, bwd_q, cost_q;
  logic                    done_q;
  logic [DIST_W-1:0]       fwd_out_q, bwd_out_q, cost_out_q;
  logic                    gate_out_q;

  // Every cycle accepts a beat; the pipeline never backs up.
  assign busy        = 1'b0;
  assign take        = start & ~busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= GATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_dist_q <= cfg_data_i;
    end
  end

  // Forward uses obj - track, backward track - obj; clamp both to the limit.
  always_comb begin
    dtf_full = $signed({1'b0, obj_time_i}) - $signed({1'b0, track_time_i});
    dtb_full = $signed({1'b0, track_time_i}) - $signed({1'b0, obj_time_i});
    if (dtf_full > DT_HI) begin
      dtf_c = DT_HI;
    end else if (dtf_full < DT_LO) begin
      dtf_c = DT_LO;
    end else begin
      dtf_c = dtf_full;
    end
    if (dtb_full > DT_HI) begin
      dtb_c = DT_HI;
    end else if (dtb_full < DT_LO) begin
      dtb_c = DT_LO;
    end else begin
      dtb_c = dtb_full;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    dtf_q <= dtf_c[DT_W-1:0];
    dtb_q <= dtb_c[DT_W-1:0];
    tx_q  <= track_x_i;
    ty_q  <= track_y_i;
    tvx_q <= track_vx_i;
    tvy_q <= track_vy_i;
    ox_q  <= obj_x_i;
    oy_q  <= obj_y_i;
    ovx_q <= obj_vx_i;
    ovy_q <= obj_vy_i;
  end

  // Track moved to object time, compared with object position.
  mcpd_resid #(
    .DT_LIMIT_BITS (DT_LIMIT_BITS)
  ) u_resid_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .ax_i    (tx_q),
    .ay_i    (ty_q),
    .vx_i    (tvx_q),
    .vy_i    (tvy_q),
    .bx_i    (ox_q),
    .by_i    (oy_q),
    .dt_i    (dtf_q),
    .valid_o (fres_v),
    .sum_o   (fres_sum)
  );

  // Object moved to track time, compared with track position.
  mcpd_resid #(
    .DT_LIMIT_BITS (DT_LIMIT_BITS)
  ) u_resid_bwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .ax_i    (ox_q),
    .ay_i    (oy_q),
    .vx_i    (ovx_q),
    .vy_i    (ovy_q),
    .bx_i    (tx_q),
    .by_i    (ty_q),
    .dt_i    (dtb_q),
    .valid_o (bres_v),
    .sum_o   (bres_sum)
  );

  mcpd_isqrt #(
    .IN_W (SUM_W)
  ) u_isqrt_fwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fres_v),
    .rad_i   (fres_sum),
    .valid_o (fdist_v),
    .dist_o  (fdist)
  );

  mcpd_isqrt #(
    .IN_W (SUM_W)
  ) u_isqrt_bwd (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (bres_v),
    .rad_i   (bres_sum),
    .valid_o (bdist_v),
    .dist_o  (bdist)
  );

  // Both lanes run in lockstep; both valids together mark the beat.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vc_q   <= fdist_v & bdist_v;
      done_q <= vc_q;
    end
  end

  // Average rounds down; gate on a strict compare against the threshold.
  always_ff @(posedge clk_i) begin
    fwd_q      <= fdist;
    bwd_q      <= bdist;
    cost_q     <= DIST_W'(((DIST_W+1)'(fdist) + (DIST_W+1)'(bdist)) >> 1);
    fwd_out_q  <= fwd_q;
    bwd_out_q  <= bwd_q;
    cost_out_q <= cost_q;
    gate_out_q <= (cost_q < max_dist_q);
  end

  assign done            = done_q;
  assign forward_dist_o  = fwd_out_q;
  assign backward_dist_o = bwd_out_q;
  assign pair_cost_o     = cost_out_q;
  assign within_gate_o   = gate_out_q;

endmodule

// ----- sim/motion_compensated_pair_distance_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_compensated_pair_distance_tb: self-checking bench for the pair distance
// Drives track/object pairs through the command port with random gaps and
// predicts forward and backward residuals, the averaged cost and the gate flag
// for every accepted beat. Each done strobe is compared field by field against
// the oldest prediction. The gate threshold is rewritten between phases while
// the pipeline is empty.
// ----------------------------------------------------------------------------
module motion_compensated_pair_distance_tb;
  import mcpd_pkg::*;

  localparam int      DT_LIMIT_BITS = 20;
  localparam int      LATENCY       = 34;        // used only for the final drain wait
  localparam longint  DT_LIM        = longint'(1) << DT_LIMIT_BITS;
  localparam longint  POS_MAX       = (longint'(1) << (POS_W - 1)) - 1;
  localparam longint  POS_MIN       = -(longint'(1) << (POS_W - 1));
  localparam longint  VEL_MAX       = (longint'(1) << (VEL_W - 1)) - 1;
  localparam longint  VEL_MIN       = -(longint'(1) << (VEL_W - 1));
  localparam longint  TIME_MAX      = (longint'(1) << TIME_W) - 1;
  localparam longint  TIMEOUT_NS    = 64'd2_000_000;

  typedef struct {
    logic signed [POS_W-1:0] tx, ty;
    logic signed [VEL_W-1:0] tvx, tvy;
    logic [TIME_W-1:0]       tt;
    logic signed [POS_W-1:0] ox, oy;
    logic signed [VEL_W-1:0] ovx, ovy;
    logic [TIME_W-1:0]       ot;
  } pair_t;

  typedef struct {
    logic [DIST_W-1:0] fwd;
    logic [DIST_W-1:0] bwd;
    logic [DIST_W-1:0] cost;
    logic              gate;
    logic              clamped;   // bookkeeping only, not compared
  } pair_dist_t;

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                    clk_i        = 1'b0;
  logic                    rst_ni       = 1'b0;
  logic                    start        = 1'b0;
  logic                    busy;
  logic signed [POS_W-1:0] track_x_i    = '0;
  logic signed [POS_W-1:0] track_y_i    = '0;
  logic signed [VEL_W-1:0] track_vx_i   = '0;
  logic signed [VEL_W-1:0] track_vy_i   = '0;
  logic [TIME_W-1:0]       track_time_i = '0;
  logic signed [POS_W-1:0] obj_x_i      = '0;
  logic signed [POS_W-1:0] obj_y_i      = '0;
  logic signed [VEL_W-1:0] obj_vx_i     = '0;
  logic signed [VEL_W-1:0] obj_vy_i     = '0;
  logic [TIME_W-1:0]       obj_time_i   = '0;
  logic                    done;
  logic [DIST_W-1:0]       forward_dist_o;
  logic [DIST_W-1:0]       backward_dist_o;
  logic [DIST_W-1:0]       pair_cost_o;
  logic                    within_gate_o;
  logic                    cfg_valid_i  = 1'b0;
  logic                    cfg_ready_o;
  logic [DIST_W-1:0]       cfg_data_i   = '0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  motion_compensated_pair_distance #(
    .DT_LIMIT_BITS (DT_LIMIT_BITS)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .track_x_i       (track_x_i),
    .track_y_i       (track_y_i),
    .track_vx_i      (track_vx_i),
    .track_vy_i      (track_vy_i),
    .track_time_i    (track_time_i),
    .obj_x_i         (obj_x_i),
    .obj_y_i         (obj_y_i),
    .obj_vx_i        (obj_vx_i),
    .obj_vy_i        (obj_vy_i),
    .obj_time_i      (obj_time_i),
    .done            (done),
    .forward_dist_o  (forward_dist_o),
    .backward_dist_o (backward_dist_o),
    .pair_cost_o     (pair_cost_o),
    .within_gate_o   (within_gate_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  // --------------------------------------------------------------------------
  // Bench state: threshold copy, pending distances, run statistics
  // --------------------------------------------------------------------------
  logic [DIST_W-1:0] gate_threshold = GATE_RESET;  // mirrors the DUT register
  pair_dist_t        pending_dists[$];             // oldest prediction at the front
  bit                gaps_on        = 1'b1;        // sender idling enabled
  int                n_fail         = 0;
  int                n_sent         = 0;
  int                n_checked      = 0;
  int                n_gate_open    = 0;
  int                n_clamped      = 0;
  int                n_thresholds   = 1;

  // --------------------------------------------------------------------------
  // Distance predictor
  // --------------------------------------------------------------------------

  // Floor of the square root, one result bit per pass.
  function automatic longint unsigned floor_isqrt(input longint unsigned n);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem  = n;
    root = 0;
    bitv = longint'(1) << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  -= root + bitv;
        root  = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // Move observation a by dt ticks along its velocity, measure against b.
  // The arithmetic shift floors the 2^-26 m displacement toward minus infinity.
  function automatic logic [DIST_W-1:0] residual_dist(input longint ax, input longint ay,
                                                      input longint vx, input longint vy,
                                                      input longint bx, input longint by,
                                                      input longint dt);
    longint          rx;
    longint          ry;
    longint unsigned d;
    rx = bx - ax - ((vx * dt) >>> FRAC_SHIFT);
    ry = by - ay - ((vy * dt) >>> FRAC_SHIFT);
    d  = floor_isqrt(longint'(rx * rx) + longint'(ry * ry));
    return (d > DIST_MAX) ? DIST_MAX : DIST_W'(d);
  endfunction

  function automatic pair_dist_t predict_pair_distance(input pair_t p);
    pair_dist_t        r;
    longint            dt;
    logic [DIST_W:0]   dist_sum;
    dt = longint'({16'd0, p.ot}) - longint'({16'd0, p.tt});
    r.clamped = (dt > DT_LIM) || (dt < -DT_LIM);
    if (dt > DT_LIM)  dt = DT_LIM;
    if (dt < -DT_LIM) dt = -DT_LIM;
    r.fwd = residual_dist(longint'(p.tx), longint'(p.ty), longint'(p.tvx), longint'(p.tvy),
                          longint'(p.ox), longint'(p.oy), dt);
    r.bwd = residual_dist(longint'(p.ox), longint'(p.oy), longint'(p.ovx), longint'(p.ovy),
                          longint'(p.tx), longint'(p.ty), -dt);
    dist_sum = {1'b0, r.fwd} + {1'b0, r.bwd};
    r.cost   = dist_sum[DIST_W:1];
    r.gate   = (r.cost < gate_threshold);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic pair_t mk_pair(input longint tx, input longint ty,
                                    input longint tvx, input longint tvy, input longint tt,
                                    input longint ox, input longint oy,
                                    input longint ovx, input longint ovy, input longint ot);
    pair_t p;
    p.tx  = POS_W'(tx);   p.ty  = POS_W'(ty);
    p.tvx = VEL_W'(tvx);  p.tvy = VEL_W'(tvy);  p.tt = TIME_W'(tt);
    p.ox  = POS_W'(ox);   p.oy  = POS_W'(oy);
    p.ovx = VEL_W'(ovx);  p.ovy = VEL_W'(ovy);  p.ot = TIME_W'(ot);
    return p;
  endfunction

  // Mostly plausible pairs: nearby positions, similar velocities and times a
  // couple of seconds apart, so costs land around the threshold. The rest is
  // raw noise over every bit, with some pairs far apart in time.
  function automatic pair_t random_pair(input int span);
    pair_t  p;
    int     kind;
    longint delta;
    kind  = $urandom_range(0, 7);
    p.tx  = POS_W'($urandom);  p.ty  = POS_W'($urandom);
    p.tvx = VEL_W'($urandom);  p.tvy = VEL_W'($urandom);
    p.tt  = TIME_W'({$urandom, $urandom});
    p.ox  = POS_W'($urandom);  p.oy  = POS_W'($urandom);
    p.ovx = VEL_W'($urandom);  p.ovy = VEL_W'($urandom);
    p.ot  = TIME_W'({$urandom, $urandom});
    if (kind < 5) begin
      p.tvx = VEL_W'(int'($urandom_range(0, 8192)) - 4096);
      p.tvy = VEL_W'(int'($urandom_range(0, 8192)) - 4096);
      p.ovx = VEL_W'(int'(p.tvx) + int'($urandom_range(0, 2048)) - 1024);
      p.ovy = VEL_W'(int'(p.tvy) + int'($urandom_range(0, 2048)) - 1024);
      delta = longint'($urandom_range(0, 1 << 18)) - (longint'(1) << 17);
      p.ot  = p.tt + TIME_W'(delta);
      p.ox  = POS_W'(int'(p.tx) + int'($urandom_range(0, 2 * span)) - span);
      p.oy  = POS_W'(int'(p.ty) + int'($urandom_range(0, 2 * span)) - span);
    end else if (kind == 5) begin
      // push the time difference right around and beyond the clamp
      delta = DT_LIM + longint'($urandom_range(0, 64)) - 32;
      p.ot  = $urandom_range(0, 1) ? p.tt + TIME_W'(delta) : p.tt - TIME_W'(delta);
    end
    return p;
  endfunction

  // Send one pair: optional random gap, then hold start until a beat is taken.
  // start stays high afterwards so back-to-back pairs need no extra edge;
  // whoever pauses the sender lowers it.
  task automatic send_pair(input pair_t p);
    int         gap;
    pair_dist_t r;
    gap = gaps_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start        <= 1'b1;
    track_x_i    <= p.tx;   track_y_i  <= p.ty;
    track_vx_i   <= p.tvx;  track_vy_i <= p.tvy;
    track_time_i <= p.tt;
    obj_x_i      <= p.ox;   obj_y_i    <= p.oy;
    obj_vx_i     <= p.ovx;  obj_vy_i   <= p.ovy;
    obj_time_i   <= p.ot;
    do @(posedge clk_i); while (busy);
    r = predict_pair_distance(p);
    pending_dists = {pending_dists, r};
    n_sent++;
    if (r.gate)    n_gate_open++;
    if (r.clamped) n_clamped++;
  endtask

  // Drop start and hold until every predicted distance has come back.
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_dists.size() != 0);
  endtask

  // Write the gate threshold with the pipeline empty.
  task automatic write_threshold(input logic [DIST_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    gate_threshold = value;
    n_thresholds++;
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Result checker: every done beat against the oldest prediction
  // --------------------------------------------------------------------------
  function automatic void report_field(input string name, input logic [DIST_W-1:0] exp_v,
                                       input logic [DIST_W-1:0] act_v);
    if (exp_v !== act_v) begin
      n_fail++;
      $display("%0t: mismatch on %s, expected %0d, got %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk_i) begin
    pair_dist_t want;
    if (rst_ni && done) begin
      if (pending_dists.size() == 0) begin
        n_fail++;
        $display("%0t: result with nothing pending, expected none, got cost %0d",
                 $time, pair_cost_o);
      end else begin
        want = pending_dists.pop_front();
        report_field("forward_dist",  want.fwd,  forward_dist_o);
        report_field("backward_dist", want.bwd,  backward_dist_o);
        report_field("pair_cost",     want.cost, pair_cost_o);
        report_field("within_gate",   DIST_W'(want.gate), DIST_W'(within_gate_o));
        n_checked++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Reset threshold of 4096: costs of zero, just below, exactly at and just above it.
  task automatic test_reset_threshold();
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk_pair(0, 0, 0, 0, 0, 4095, 0, 0, 0, 0));
    send_pair(mk_pair(0, 0, 0, 0, 0, 4096, 0, 0, 0, 0));
    send_pair(mk_pair(100, 200, 0, 0, 7, 100, 200 - 4097, 0, 0, 7));
  endtask

  // Field extremes, time clamp on both sides and the flooring of displacement.
  task automatic test_field_extremes();
    send_pair(mk_pair(POS_MIN, POS_MIN, 0, 0, 0, POS_MAX, POS_MAX, 0, 0, 0));
    send_pair(mk_pair(POS_MAX, POS_MAX, 0, 0, TIME_MAX, POS_MIN, POS_MIN, 0, 0, TIME_MAX));
    // object far in the future: dt clamps to the positive limit
    send_pair(mk_pair(0, 0, VEL_MAX, VEL_MAX, 0, 0, 0, VEL_MAX, VEL_MAX, TIME_MAX));
    // object far in the past: dt clamps to the negative limit
    send_pair(mk_pair(0, 0, VEL_MIN, VEL_MIN, TIME_MAX, 0, 0, VEL_MIN, VEL_MIN, 0));
    send_pair(mk_pair(5, -5, VEL_MAX, VEL_MIN, 1000, -5, 5, VEL_MIN, VEL_MAX, 1000 + DT_LIM));
    send_pair(mk_pair(5, -5, VEL_MAX, VEL_MIN, 1000, -5, 5, VEL_MIN, VEL_MAX,
                      1000 + DT_LIM + 1));
    send_pair(mk_pair(0, 0, VEL_MAX, VEL_MAX, DT_LIM, 0, 0, VEL_MIN, VEL_MIN, 0));
    send_pair(mk_pair(0, 0, VEL_MAX, VEL_MAX, DT_LIM + 1, 0, 0, VEL_MIN, VEL_MIN, 0));
    // one tick at -1 and +1 velocity: floor gives -1 and 0
    send_pair(mk_pair(0, 0, -1, -1, 100, 0, 0, 1, 1, 101));
    send_pair(mk_pair(0, 0, 1, 1, 100, 0, 0, -1, -1, 101));
    send_pair(mk_pair(POS_MAX, POS_MIN, VEL_MAX, VEL_MIN, 0, POS_MIN, POS_MAX,
                      VEL_MIN, VEL_MAX, 12345));
    // consistent motion: 1 m/s over 1 s lands exactly on the other observation
    send_pair(mk_pair(0, 0, 1024, 0, 65536, 1024, 0, 1024, 0, 131072));
  endtask

  // Threshold zero closes the gate for everything; the maximum opens it.
  task automatic test_gate_extremes();
    write_threshold('0);
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_pair(mk_pair(0, 0, 0, 0, 0, 5, 0, 0, 0, 0));
    write_threshold(DIST_MAX);
    send_pair(mk_pair(POS_MIN, POS_MIN, 0, 0, 0, POS_MAX, POS_MAX, 0, 0, 0));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Random pairs over several thresholds, idle and no-idle stretches, and one
  // full drain in the middle of a phase.
  task automatic test_random_pairs();
    logic [DIST_W-1:0] thr;
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin thr = DIST_W'($urandom_range(0, 16383)); end
        1: begin thr = DIST_W'($urandom); end
        2: begin thr = DIST_W'(1); end
        3: begin thr = DIST_W'($urandom_range(1024, 8192)); end
        default: begin thr = GATE_RESET; end
      endcase
      write_threshold(thr);
      for (int i = 0; i < 260; i++) begin
        if (i % 40 == 0) gaps_on = ($urandom_range(0, 2) != 0);
        if (phase == 2 && i == 130) wait_drained();
        send_pair(random_pair((phase == 1) ? 1 << 20 : 8192));
      end
    end
    gaps_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_threshold();
    test_field_extremes();
    test_gate_extremes();
    test_random_pairs();

    wait_drained();
    repeat (LATENCY + 10) @(posedge clk_i);
    if (pending_dists.size() != 0) begin
      n_fail++;
      $display("%0t: %0d predicted results never arrived, expected 0 left",
               $time, pending_dists.size());
    end

    $display("Covered %0d pairs (%0d checked) over %0d gate thresholds;",
             n_sent, n_checked, n_thresholds);
    $display("%0d pairs inside the gate, %0d with the time difference clamped.",
             n_gate_open, n_clamped);
    if (n_fail == 0) begin
      $display("PASS motion_compensated_pair_distance");
    end else begin
      $display("FAIL motion_compensated_pair_distance");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL motion_compensated_pair_distance");
    $finish;
  end

endmodule
